/* design/tte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP transfer engine package
// Shared field widths, codes and payload types of the transfer engine.
// ----------------------------------------------------------------------------
package tte_pkg;

	localparam int OP_W    = 2;
	localparam int OPC_W   = 16;
	localparam int BLK_W   = 16;
	localparam int LEN_W   = 10;
	localparam int ERR_W   = 3;
	localparam int ACT_W   = 3;
	localparam int OUTC_W  = 2;
	localparam int RETRY_W = 4;
	localparam int PK_W    = 3;

	localparam int BLOCK_BYTES = 512;
	localparam logic [LEN_W-1:0] BLOCK_LEN = LEN_W'(BLOCK_BYTES);
	localparam logic [RETRY_W-1:0] RETRY_SAT = '1;
	localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = RETRY_W'(3);

	// Depth of the queue between the front and the back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Event kinds
	localparam logic [OP_W-1:0] OP_PACKET   = 2'd0;
	localparam logic [OP_W-1:0] OP_TIMEOUT  = 2'd1;
	localparam logic [OP_W-1:0] OP_BLOCK    = 2'd2;
	localparam logic [OP_W-1:0] OP_FILE_ERR = 2'd3;

	// Wire opcodes
	localparam logic [OPC_W-1:0] OPC_RRQ   = 16'd1;
	localparam logic [OPC_W-1:0] OPC_WRQ   = 16'd2;
	localparam logic [OPC_W-1:0] OPC_DATA  = 16'd3;
	localparam logic [OPC_W-1:0] OPC_ACK   = 16'd4;
	localparam logic [OPC_W-1:0] OPC_ERROR = 16'd5;

	// Packet classes produced by the front
	localparam logic [PK_W-1:0] PK_RRQ   = 3'd0;
	localparam logic [PK_W-1:0] PK_WRQ   = 3'd1;
	localparam logic [PK_W-1:0] PK_DATA  = 3'd2;
	localparam logic [PK_W-1:0] PK_ACK   = 3'd3;
	localparam logic [PK_W-1:0] PK_ERROR = 3'd4;
	localparam logic [PK_W-1:0] PK_OTHER = 3'd5;

	// Actions
	localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ACK    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DATA   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RESEND = 3'd3;
	localparam logic [ACT_W-1:0] ACT_ERROR  = 3'd4;

	// Outcomes
	localparam logic [OUTC_W-1:0] OUTC_BUSY = 2'd0;
	localparam logic [OUTC_W-1:0] OUTC_DONE = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_FAIL = 2'd2;

	localparam logic [ERR_W-1:0] ERR_ILLEGAL = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [OPC_W-1:0] opcode;
		logic [BLK_W-1:0] block_number;
		logic [LEN_W-1:0] payload_length;
		logic [ERR_W-1:0] file_error_code;
	} req_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [BLK_W-1:0]  out_block;
		logic [LEN_W-1:0]  out_length;
		logic [ERR_W-1:0]  error_code;
		logic [OUTC_W-1:0] outcome;
	} rsp_t;

	// Classified event as it travels through the queue
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [PK_W-1:0]  pkt;
		logic [BLK_W-1:0] blk;
		logic [LEN_W-1:0] len;
		logic             short_blk;
		logic [ERR_W-1:0] ferr;
	} cls_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* design/tte_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP transfer engine front
// Takes requests, decodes the opcode and clamps the length into one stage.
// ----------------------------------------------------------------------------
module tte_front import tte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_t      req,
	output logic      push,
	output cls_t      push_data,
	input  q_status_t q_status
);

	logic valid_s1;
	cls_t cls_s1;
	cls_t cls_d;
	logic accept;

	always_comb begin
		cls_d.op        = req.operation;
		cls_d.blk       = req.block_number;
		cls_d.ferr      = req.file_error_code;
		cls_d.short_blk = (req.payload_length < BLOCK_LEN);
		cls_d.len       = cls_d.short_blk ? req.payload_length : BLOCK_LEN;
		unique case (req.opcode)
			OPC_RRQ:   cls_d.pkt = PK_RRQ;
			OPC_WRQ:   cls_d.pkt = PK_WRQ;
			OPC_DATA:  cls_d.pkt = PK_DATA;
			OPC_ACK:   cls_d.pkt = PK_ACK;
			OPC_ERROR: cls_d.pkt = PK_ERROR;
			default:   cls_d.pkt = PK_OTHER;
		endcase
	end

	assign push      = valid_s1 && !q_status.full;
	assign push_data = cls_s1;
	assign req_stall = valid_s1 && q_status.full;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

/* design/tte_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP transfer engine queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module tte_queue import tte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_t      push_data,
	input  logic      pop,
	output cls_t      head,
	output q_status_t q_status
);

	cls_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		ptr_next = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign q_status.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_status.empty = (count_q == '0);
	assign head           = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* design/tte_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP transfer engine back
// Holds the transfer state, executes one classified event per cycle while the response is not stalled, and
// registers the result for the response channel.
// ----------------------------------------------------------------------------
module tte_back import tte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [RETRY_W-1:0] retry_limit,
	input  cls_t               head,
	input  q_status_t          q_status,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp
);

	localparam logic [1:0] PH_IDLE       = 2'd0;
	localparam logic [1:0] PH_NEED_BLOCK = 2'd1;
	localparam logic [1:0] PH_WAIT_ACK   = 2'd2;
	localparam logic [1:0] PH_RECV       = 2'd3;

	logic [1:0]         phase_q;
	logic [BLK_W-1:0]   block_q;
	logic [RETRY_W-1:0] retry_q;
	logic [LEN_W-1:0]   last_len_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [1:0]         phase_d;
	logic [BLK_W-1:0]   block_d;
	logic [RETRY_W-1:0] retry_d;
	logic [LEN_W-1:0]   last_len_d;
	logic [RETRY_W-1:0] retry_inc;
	logic [BLK_W-1:0]   prev_blk;
	rsp_t               res;

	assign pop       = !q_status.empty && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign prev_blk  = block_q - BLK_W'(1);
	assign retry_inc = (retry_q != RETRY_SAT) ? retry_q + RETRY_W'(1) : retry_q;

	always_comb begin
		phase_d    = phase_q;
		block_d    = block_q;
		retry_d    = retry_q;
		last_len_d = last_len_q;
		res        = '0;
		res.action  = ACT_NONE;
		res.outcome = OUTC_BUSY;
		unique case (phase_q)
			PH_IDLE: begin
				if (head.op == OP_PACKET) begin
					if (head.pkt == PK_RRQ) begin
						phase_d = PH_NEED_BLOCK;
						block_d = BLK_W'(1);
						retry_d = '0;
					end else if (head.pkt == PK_WRQ) begin
						phase_d    = PH_RECV;
						block_d    = BLK_W'(1);
						res.action = ACT_ACK;
					end else begin
						res.action     = ACT_ERROR;
						res.error_code = ERR_ILLEGAL;
						res.outcome    = OUTC_FAIL;
					end
				end
			end
			PH_NEED_BLOCK: begin
				if (head.op == OP_BLOCK) begin
					last_len_d     = head.len;
					retry_d        = '0;
					phase_d        = PH_WAIT_ACK;
					res.action     = ACT_DATA;
					res.out_block  = block_q;
					res.out_length = head.len;
				end else if (head.op == OP_FILE_ERR) begin
					phase_d        = PH_IDLE;
					res.action     = ACT_ERROR;
					res.error_code = head.ferr;
					res.outcome    = OUTC_FAIL;
				end
			end
			PH_WAIT_ACK: begin
				if (head.op == OP_PACKET || head.op == OP_TIMEOUT) begin
					if (head.op == OP_PACKET && head.pkt == PK_ACK && head.blk == block_q) begin
						if (last_len_q < BLOCK_LEN) begin
							phase_d     = PH_IDLE;
							res.outcome = OUTC_DONE;
						end else begin
							block_d = block_q + BLK_W'(1);
							phase_d = PH_NEED_BLOCK;
						end
					end else begin
						// The saturated count is compared, so a limit of zero fails at once.
						retry_d = retry_inc;
						if (retry_inc >= retry_limit) begin
							phase_d     = PH_IDLE;
							res.outcome = OUTC_FAIL;
						end else begin
							res.action     = ACT_RESEND;
							res.out_block  = block_q;
							res.out_length = last_len_q;
						end
					end
				end
			end
			PH_RECV: begin
				case (head.op)
					OP_FILE_ERR: begin
						phase_d        = PH_IDLE;
						res.action     = ACT_ERROR;
						res.error_code = head.ferr;
						res.outcome    = OUTC_FAIL;
					end
					OP_TIMEOUT: begin
						phase_d     = PH_IDLE;
						res.outcome = OUTC_FAIL;
					end
					OP_PACKET: begin
						if (head.pkt == PK_DATA) begin
							if (head.blk == block_q) begin
								res.action    = ACT_ACK;
								res.out_block = block_q;
								if (head.short_blk) begin
									phase_d     = PH_IDLE;
									res.outcome = OUTC_DONE;
								end else begin
									block_d = block_q + BLK_W'(1);
								end
							end else if (head.blk == prev_blk && prev_blk != '0) begin
								// Duplicate of the previous block: acknowledge it again.
								res.action    = ACT_ACK;
								res.out_block = prev_blk;
							end else begin
								phase_d        = PH_IDLE;
								res.action     = ACT_ERROR;
								res.error_code = ERR_ILLEGAL;
								res.outcome    = OUTC_FAIL;
							end
						end else if (head.pkt == PK_ERROR) begin
							phase_d     = PH_IDLE;
							res.outcome = OUTC_FAIL;
						end else begin
							phase_d        = PH_IDLE;
							res.action     = ACT_ERROR;
							res.error_code = ERR_ILLEGAL;
							res.outcome    = OUTC_FAIL;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			block_q     <= '0;
			retry_q     <= '0;
			last_len_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				block_q     <= block_d;
				retry_q     <= retry_d;
				last_len_q  <= last_len_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q <= res;
		end
	end

endmodule

/* design/tftp_transfer_engine_top.sv */
`timescale 1ns / 1ps
// Path: a request is registered in the front stage, written into the two-entry queue, then
// executed by the back, which registers its result onto rsp.
// Throughput: one request per cycle while rsp is not stalled; during a stall the front
// register and the two-entry queue take up to three more requests before req_stall rises.
// Reset (arst_n low): idle phase, block counter, retry count and last length
// cleared, retry limit back to 3, queue and output register emptied.
// ----------------------------------------------------------------------------
// TFTP transfer engine top level
// Server-side lock-step TFTP transfer engine: front, queue and back.
// ----------------------------------------------------------------------------
module tftp_transfer_engine_top import tte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [RETRY_W-1:0] cfg_data
);

	logic               push;
	logic               pop;
	cls_t               push_data;
	cls_t               head;
	q_status_t          q_status;
	logic [RETRY_W-1:0] retry_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			retry_limit_q <= cfg_data;
		end
	end

	tte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_data (push_data),
		.q_status  (q_status)
	);

	tte_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_status  (q_status)
	);

	tte_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.retry_limit (retry_limit_q),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp)
	);

endmodule

/* design/tte_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP transfer engine checker
// Port-level assertions on the response and configuration channels.
// ----------------------------------------------------------------------------
module tte_checker import tte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp,
	input logic cfg_valid,
	input logic cfg_ready
);

	// A stalled response must be held unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// Only data and resend carry a length; only an error carries a code.
	a_rsp_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.out_length == '0) || rsp.action == ACT_DATA
			|| rsp.action == ACT_RESEND)
			&& ((rsp.error_code == '0) || rsp.action == ACT_ERROR))
		else $error("response carries fields its action does not use");

	// An error packet always ends the transfer as failed.
	a_error_fails: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.action == ACT_ERROR |-> rsp.outcome == OUTC_FAIL)
		else $error("error sent without failing the transfer");

	// A completed transfer ends with an ack or with nothing to send.
	a_done_action: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.outcome == OUTC_DONE
			|-> rsp.action == ACT_NONE || rsp.action == ACT_ACK)
		else $error("completion reported with a data or error packet");

	// The register write channel never holds off a write.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind tftp_transfer_engine_top tte_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TFTP transfer engine testbench
// Drives packet, timeout and local events into the engine and checks every
// response against a cycle-free model of the lock-step send and receive
// transfers or a directed row's value. A short table of directed requests comes
// first, then random transfers under several retry limits and idling patterns.
// ----------------------------------------------------------------------------
module tb import tte_pkg::*; ();

	typedef enum logic [1:0] {ST_IDLE, ST_NEED_BLOCK, ST_WAIT_ACK, ST_RECEIVE} xfer_phase_t;

	typedef struct {
		req_t stim;
		bit   known;
		rsp_t want;
	} dir_row_t;

	localparam rsp_t IDLE_RSP       = '0;
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   SEG_ITEMS      = 152;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [RETRY_W-1:0] cfg_data = '0;

	// Model state of the engine.
	xfer_phase_t        xfer_phase = ST_IDLE;
	logic [BLK_W-1:0]   cur_block = '0;
	logic [RETRY_W-1:0] ack_misses = '0;
	logic [LEN_W-1:0]   sent_len = '0;
	logic [RETRY_W-1:0] miss_limit = RETRY_LIMIT_RST;

	rsp_t        responses_due[$];
	dir_row_t    dir_rows[$];
	int unsigned snd_idle_pct = 6;
	int unsigned rcv_idle_pct = 67;
	int unsigned issued = 0;
	int unsigned checked = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	tftp_transfer_engine_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic req_t mk_req(input logic [OP_W-1:0] op, input logic [OPC_W-1:0] opc,
			input logic [BLK_W-1:0] blk, input logic [LEN_W-1:0] len,
			input logic [ERR_W-1:0] ferr);
		req_t r;
		r.operation       = op;
		r.opcode          = opc;
		r.block_number    = blk;
		r.payload_length  = len;
		r.file_error_code = ferr;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(input logic [ACT_W-1:0] act, input logic [BLK_W-1:0] blk,
			input logic [LEN_W-1:0] len, input logic [ERR_W-1:0] err,
			input logic [OUTC_W-1:0] outc);
		rsp_t o;
		o.action     = act;
		o.out_block  = blk;
		o.out_length = len;
		o.error_code = err;
		o.outcome    = outc;
		return o;
	endfunction

	// Applies one event to the model state and returns the packet to emit.
	function automatic rsp_t engine_step(input req_t r);
		rsp_t             o;
		logic [BLK_W-1:0] prev_block;
		o = IDLE_RSP;
		prev_block = cur_block - 16'd1;
		case (xfer_phase)
			ST_IDLE: begin
				if (r.operation == OP_PACKET) begin
					if (r.opcode == OPC_RRQ) begin
						xfer_phase = ST_NEED_BLOCK;
						cur_block = 16'd1;
						ack_misses = '0;
					end else if (r.opcode == OPC_WRQ) begin
						xfer_phase = ST_RECEIVE;
						cur_block = 16'd1;
						o.action = ACT_ACK;
					end else begin
						o = mk_rsp(ACT_ERROR, '0, '0, ERR_ILLEGAL, OUTC_FAIL);
					end
				end
			end
			ST_NEED_BLOCK: begin
				if (r.operation == OP_BLOCK) begin
					sent_len = (r.payload_length > BLOCK_LEN) ? BLOCK_LEN : r.payload_length;
					ack_misses = '0;
					xfer_phase = ST_WAIT_ACK;
					o = mk_rsp(ACT_DATA, cur_block, sent_len, '0, OUTC_BUSY);
				end else if (r.operation == OP_FILE_ERR) begin
					xfer_phase = ST_IDLE;
					o = mk_rsp(ACT_ERROR, '0, '0, r.file_error_code, OUTC_FAIL);
				end
			end
			ST_WAIT_ACK: begin
				if (r.operation == OP_PACKET && r.opcode == OPC_ACK
						&& r.block_number == cur_block) begin
					if (sent_len < BLOCK_LEN) begin
						xfer_phase = ST_IDLE;
						o.outcome = OUTC_DONE;
					end else begin
						cur_block = cur_block + 16'd1;
						xfer_phase = ST_NEED_BLOCK;
					end
				end else if (r.operation == OP_PACKET || r.operation == OP_TIMEOUT) begin
					if (ack_misses != RETRY_SAT)
						ack_misses = ack_misses + 4'd1;
					if (ack_misses >= miss_limit) begin
						xfer_phase = ST_IDLE;
						o.outcome = OUTC_FAIL;
					end else begin
						o = mk_rsp(ACT_RESEND, cur_block, sent_len, '0, OUTC_BUSY);
					end
				end
			end
			default: begin
				if (r.operation == OP_FILE_ERR) begin
					xfer_phase = ST_IDLE;
					o = mk_rsp(ACT_ERROR, '0, '0, r.file_error_code, OUTC_FAIL);
				end else if (r.operation == OP_TIMEOUT) begin
					xfer_phase = ST_IDLE;
					o.outcome = OUTC_FAIL;
				end else if (r.operation == OP_PACKET) begin
					if (r.opcode == OPC_DATA && r.block_number == cur_block) begin
						o = mk_rsp(ACT_ACK, cur_block, '0, '0, OUTC_BUSY);
						if (r.payload_length < BLOCK_LEN) begin
							xfer_phase = ST_IDLE;
							o.outcome = OUTC_DONE;
						end else begin
							cur_block = cur_block + 16'd1;
						end
					end else if (r.opcode == OPC_DATA && r.block_number == prev_block
							&& prev_block != 16'd0) begin
						o = mk_rsp(ACT_ACK, prev_block, '0, '0, OUTC_BUSY);
					end else if (r.opcode == OPC_ERROR) begin
						xfer_phase = ST_IDLE;
						o.outcome = OUTC_FAIL;
					end else begin
						xfer_phase = ST_IDLE;
						o = mk_rsp(ACT_ERROR, '0, '0, ERR_ILLEGAL, OUTC_FAIL);
					end
				end
			end
		endcase
		return o;
	endfunction

	// Mostly well-formed traffic for the current phase, with some noise.
	function automatic req_t pick_request();
		req_t        r;
		int unsigned dice;
		int unsigned pick;
		r.operation       = OP_W'($urandom);
		r.opcode          = OPC_W'($urandom);
		r.block_number    = BLK_W'($urandom);
		r.payload_length  = LEN_W'($urandom);
		r.file_error_code = ERR_W'($urandom);
		dice = $urandom_range(99);
		pick = $urandom_range(9);
		if (dice < 8)
			return r;
		case (xfer_phase)
			ST_IDLE: begin
				r.operation = OP_PACKET;
				if (dice < 53)
					r.opcode = OPC_RRQ;
				else if (dice < 95)
					r.opcode = OPC_WRQ;
			end
			ST_NEED_BLOCK: begin
				if (dice < 95) begin
					r.operation = OP_BLOCK;
					if (pick < 6)
						r.payload_length = BLOCK_LEN;
					else if (pick < 8)
						r.payload_length = LEN_W'($urandom_range(511));
					else
						r.payload_length = LEN_W'($urandom_range(1023, 513));
				end else begin
					r.operation = OP_FILE_ERR;
				end
			end
			ST_WAIT_ACK: begin
				r.operation = OP_PACKET;
				if (dice < 80) begin
					r.opcode = OPC_ACK;
					r.block_number = cur_block;
				end else if (pick < 3) begin
					r.operation = OP_TIMEOUT;
				end else if (pick < 6) begin
					r.opcode = OPC_ACK;
					r.block_number = cur_block + BLK_W'($urandom_range(65535, 1));
				end else if (pick < 8) begin
					r.opcode = OPC_ERROR;
				end else if (pick < 9) begin
					r.opcode = OPC_DATA;
				end
			end
			default: begin
				r.operation = OP_PACKET;
				r.opcode = OPC_DATA;
				if (dice < 75) begin
					r.block_number = cur_block;
					if (pick < 7)
						r.payload_length = BLOCK_LEN;
					else if (pick < 9)
						r.payload_length = LEN_W'($urandom_range(511));
					else
						r.payload_length = LEN_W'($urandom_range(1023, 512));
				end else if (dice < 85) begin
					r.block_number = cur_block - 16'd1;
				end else if (dice < 88) begin
					r.block_number = cur_block + BLK_W'($urandom_range(65534, 1));
				end else if (dice < 91) begin
					r.operation = OP_TIMEOUT;
				end else if (dice < 94) begin
					r.opcode = OPC_ERROR;
				end else if (dice < 97) begin
					r.operation = OP_FILE_ERR;
				end else if (pick < 5) begin
					r.operation = OP_BLOCK;
				end else begin
					r.opcode = (pick < 8) ? OPC_ACK : OPC_RRQ;
				end
			end
		endcase
		return r;
	endfunction

	// Offers one request, waits for it to be taken and records the response expected for it.
	task automatic issue(input req_t r, input bit known, input rsp_t want);
		rsp_t pred;
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		pred = engine_step(r);
		responses_due.push_back(known ? want : pred);
		issued++;
	endtask

	// Writes the retry limit once every outstanding response has come back.
	task automatic set_retry_limit(input logic [RETRY_W-1:0] value);
		req_valid <= 1'b0;
		while (responses_due.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		miss_limit = value;
	endtask

	always @(posedge clk) begin : rsp_check
		rsp_t expd;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (responses_due.size() == 0) begin
				$error("response with nothing outstanding: %h", rsp);
				mismatches++;
			end else begin
				expd = responses_due.pop_front();
				checked++;
				if (rsp.action != expd.action) begin
					$error("action: expected %0d, got %0d", expd.action, rsp.action);
					mismatches++;
				end
				if (rsp.out_block != expd.out_block) begin
					$error("out_block: expected %0d, got %0d", expd.out_block, rsp.out_block);
					mismatches++;
				end
				if (rsp.out_length != expd.out_length) begin
					$error("out_length: expected %0d, got %0d", expd.out_length,
						rsp.out_length);
					mismatches++;
				end
				if (rsp.error_code != expd.error_code) begin
					$error("error_code: expected %0d, got %0d", expd.error_code,
						rsp.error_code);
					mismatches++;
				end
				if (rsp.outcome != expd.outcome) begin
					$error("outcome: expected %0d, got %0d", expd.outcome, rsp.outcome);
					mismatches++;
				end
			end
		end
		rsp_stall <= arst_n && ($urandom_range(99) < rcv_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("No handshake for %0d cycles, %0d responses outstanding",
				WATCHDOG_LIMIT, responses_due.size());
			$display("[tftp_transfer_engine_top] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [RETRY_W-1:0] lim_plan [9];
		int unsigned        target;
		lim_plan = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd2, 4'd15, 4'd1, 4'd0, 4'd5};
		lim_plan[7] = RETRY_W'($urandom_range(15));

		// Directed requests, run with the retry limit left at its reset value.
		dir_rows.push_back('{mk_req(OP_PACKET, 16'hFFFF, 16'hFFFF, 10'h3FF, 3'd7), 1'b1,
			mk_rsp(ACT_ERROR, 16'd0, 10'd0, ERR_ILLEGAL, OUTC_FAIL)});
		dir_rows.push_back('{mk_req(OP_TIMEOUT, 16'd0, 16'd0, 10'd0, 3'd0), 1'b1, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_BLOCK, 16'd0, 16'd0, 10'd0, 3'd0), 1'b1, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_RRQ, 16'd0, 10'd0, 3'd0), 1'b1, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_ACK, 16'd1, 10'd0, 3'd0), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_TIMEOUT, 16'd0, 16'd0, 10'd0, 3'd0), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_BLOCK, 16'd0, 16'd0, 10'h3FF, 3'd0), 1'b1,
			mk_rsp(ACT_DATA, 16'd1, BLOCK_LEN, 3'd0, OUTC_BUSY)});
		dir_rows.push_back('{mk_req(OP_FILE_ERR, 16'd0, 16'd0, 10'd0, 3'd5), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_ACK, 16'd0, 10'd0, 3'd0), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_ACK, 16'd1, 10'd0, 3'd0), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_BLOCK, 16'd0, 16'd0, 10'd0, 3'd0), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_ACK, 16'd2, 10'd0, 3'd0), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_RRQ, 16'd0, 10'd0, 3'd0), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_FILE_ERR, 16'd0, 16'd0, 10'd0, 3'd7), 1'b1,
			mk_rsp(ACT_ERROR, 16'd0, 10'd0, 3'd7, OUTC_FAIL)});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_WRQ, 16'd0, 10'd0, 3'd0), 1'b1,
			mk_rsp(ACT_ACK, 16'd0, 10'd0, 3'd0, OUTC_BUSY)});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_DATA, 16'd1, BLOCK_LEN, 3'd0), 1'b0,
			IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_DATA, 16'd1, BLOCK_LEN, 3'd0), 1'b0,
			IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_BLOCK, 16'd0, 16'd0, 10'd0, 3'd0), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_DATA, 16'd2, 10'h3FF, 3'd0), 1'b0,
			IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_DATA, 16'd3, 10'd511, 3'd0), 1'b0,
			IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_WRQ, 16'd0, 10'd0, 3'd0), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_DATA, 16'd0, BLOCK_LEN, 3'd0), 1'b1,
			mk_rsp(ACT_ERROR, 16'd0, 10'd0, ERR_ILLEGAL, OUTC_FAIL)});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_RRQ, 16'd0, 10'd0, 3'd0), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_BLOCK, 16'd0, 16'd0, BLOCK_LEN, 3'd0), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_TIMEOUT, 16'd0, 16'd0, 10'd0, 3'd0), 1'b0, IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_ERROR, 16'd1, 10'd0, 3'd0), 1'b0,
			IDLE_RSP});
		dir_rows.push_back('{mk_req(OP_PACKET, OPC_ACK, 16'hFFFF, 10'd0, 3'd0), 1'b0,
			IDLE_RSP});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			issue(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].want);

		for (int seg = 0; seg < 9; seg++) begin
			snd_idle_pct = (seg < 3) ? 6 : (seg < 6) ? 67 : 0;
			rcv_idle_pct = (seg < 3) ? 67 : (seg < 6) ? 6 : 0;
			set_retry_limit(lim_plan[seg]);
			target = issued + SEG_ITEMS;
			while (issued < target)
				issue(pick_request(), 1'b0, IDLE_RSP);
		end

		req_valid <= 1'b0;
		while (responses_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("Ran %0d requests (%0d directed) and checked %0d responses under retry",
			issued, dir_rows.size(), checked);
		$display("limits from 0 to 15, with stalls on either side and on neither.");
		if (mismatches == 0)
			$display("[tftp_transfer_engine_top] OK");
		else
			$display("[tftp_transfer_engine_top] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
design/tte_pkg.sv
design/tte_front.sv
design/tte_queue.sv
design/tte_back.sv
design/tftp_transfer_engine_top.sv
design/tte_checker.sv
tb/sv/tb.sv
